// ----- rtl/jmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// jmsr_pkg
// Types and constants shared by the JPEG marker stream restorer.
// ----------------------------------------------------------------------------
package jmsr_pkg;

   localparam int BYTE_W    = 8;
   localparam int CMD_SLOTS = 4;
   localparam int CNT_W     = 3;
   localparam int SLOT_W    = 2;
   localparam int LEN_W     = 16;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] MRK_PFX   = 8'hFF;
   localparam logic [BYTE_W-1:0] MRK_SOI   = 8'hD8;
   localparam logic [BYTE_W-1:0] MRK_APP   = 8'hA0;
   localparam logic [BYTE_W-1:0] MRK_SOF0  = 8'hC0;
   localparam logic [BYTE_W-1:0] MRK_DHT   = 8'hC4;
   localparam logic [BYTE_W-1:0] MRK_DQT   = 8'hDB;
   localparam logic [BYTE_W-1:0] MRK_SOS   = 8'hDA;
   localparam logic [BYTE_W-1:0] MRK_EOI   = 8'hD9;
   localparam logic [BYTE_W-1:0] SOS_LEN   = 8'h0C;
   localparam logic [BYTE_W-1:0] SOS_SE    = 8'h3F;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              unit_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              run_last;
      logic              unit_end;
      logic              malformed;
   } rsp_type;

   // One input byte's worth of output: 1 to 4 bytes plus end status.
   typedef struct packed {
      logic [CNT_W-1:0]                  count;
      logic [CMD_SLOTS-1:0][BYTE_W-1:0]  bytes;
      logic                              has_byte;
      logic                              unit_end;
      logic                              malformed;
   } cmd_type;

   typedef enum logic [9:0] {
      PH_PREFIX  = 10'b0000000001,
      PH_MARKER  = 10'b0000000010,
      PH_LEN_HI  = 10'b0000000100,
      PH_LEN_LO  = 10'b0000001000,
      PH_COPY    = 10'b0000010000,
      PH_SOS_HI  = 10'b0000100000,
      PH_SOS_LO  = 10'b0001000000,
      PH_SOS_HDR = 10'b0010000000,
      PH_SCAN    = 10'b0100000000,
      PH_DROP    = 10'b1000000000
   } phase_type;

endpackage

// ----- rtl/jmsr_front.sv -----
// ----------------------------------------------------------------------------
// jmsr_front
// Marker parser: classifies each input byte and builds its output command.
// ----------------------------------------------------------------------------
module jmsr_front import jmsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    cmd_push,
   output cmd_type cmd
);

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic              held_valid_ff, held_valid_in;

   logic [BYTE_W-1:0] b;
   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  len_m2;

   assign b      = req_data.in_byte;
   assign len    = {len_hi_ff, b};
   assign len_m2 = len - LEN_W'(2);

   always_comb begin
      cmd           = '0;
      cmd.has_byte  = 1'b1;
      phase_in      = phase_ff;
      rem_in        = rem_ff;
      len_hi_in     = len_hi_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (req_data.unit_last && (phase_ff != PH_SCAN)) begin
         cmd.count     = CNT_W'(1);
         cmd.has_byte  = 1'b0;
         cmd.unit_end  = 1'b1;
         cmd.malformed = 1'b1;
         phase_in      = PH_PREFIX;
         rem_in        = '0;
         len_hi_in     = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_PREFIX: begin
               phase_in = (b == MRK_PFX) ? PH_MARKER : PH_DROP;
            end
            PH_MARKER: begin
               unique case (b) inside
                  MRK_SOI: begin
                     cmd.count    = CNT_W'(2);
                     cmd.bytes[0] = MRK_PFX;
                     cmd.bytes[1] = MRK_SOI;
                     phase_in     = PH_PREFIX;
                  end
                  MRK_APP: begin
                     phase_in = PH_PREFIX;
                  end
                  MRK_SOF0, MRK_DHT, MRK_DQT: begin
                     cmd.count    = CNT_W'(2);
                     cmd.bytes[0] = MRK_PFX;
                     cmd.bytes[1] = b;
                     phase_in     = PH_LEN_HI;
                  end
                  MRK_SOS: begin
                     cmd.count    = CNT_W'(4);
                     cmd.bytes[0] = MRK_PFX;
                     cmd.bytes[1] = MRK_SOS;
                     cmd.bytes[2] = BYTE_ZERO;
                     cmd.bytes[3] = SOS_LEN;
                     phase_in     = PH_SOS_HI;
                  end
                  default: begin
                     phase_in = PH_DROP;
                  end
               endcase
            end
            PH_LEN_HI: begin
               len_hi_in = b;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (len < LEN_W'(2)) begin
                  phase_in = PH_DROP;
               end else begin
                  cmd.count    = CNT_W'(2);
                  cmd.bytes[0] = len_hi_ff;
                  cmd.bytes[1] = b;
                  rem_in       = len_m2;
                  phase_in     = (len_m2 == '0) ? PH_PREFIX : PH_COPY;
               end
            end
            PH_COPY: begin
               cmd.count    = CNT_W'(1);
               cmd.bytes[0] = b;
               rem_in       = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  phase_in = PH_PREFIX;
               end
            end
            PH_SOS_HI: begin
               len_hi_in = b;
               phase_in  = PH_SOS_LO;
            end
            PH_SOS_LO: begin
               if (len < LEN_W'(2)) begin
                  phase_in = PH_DROP;
               end else begin
                  rem_in = len_m2;
                  if (len_m2 == '0) begin
                     cmd.count    = CNT_W'(3);
                     cmd.bytes[0] = BYTE_ZERO;
                     cmd.bytes[1] = SOS_SE;
                     cmd.bytes[2] = BYTE_ZERO;
                     phase_in     = PH_SCAN;
                  end else begin
                     phase_in = PH_SOS_HDR;
                  end
               end
            end
            PH_SOS_HDR: begin
               cmd.bytes[0] = b;
               rem_in       = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  cmd.count    = CNT_W'(4);
                  cmd.bytes[1] = BYTE_ZERO;
                  cmd.bytes[2] = SOS_SE;
                  cmd.bytes[3] = BYTE_ZERO;
                  phase_in     = PH_SCAN;
               end else begin
                  cmd.count = CNT_W'(1);
               end
            end
            PH_SCAN: begin
               if (req_data.unit_last) begin
                  if (held_valid_ff && (held_ff == MRK_PFX)) begin
                     cmd.count    = CNT_W'(2);
                     cmd.bytes[0] = MRK_PFX;
                     cmd.bytes[1] = MRK_EOI;
                  end else begin
                     cmd.count    = CNT_W'(1);
                     cmd.bytes[0] = MRK_EOI;
                  end
                  cmd.unit_end  = 1'b1;
                  phase_in      = PH_PREFIX;
                  rem_in        = '0;
                  len_hi_in     = '0;
                  held_in       = '0;
                  held_valid_in = 1'b0;
               end else begin
                  if (held_valid_ff) begin
                     cmd.bytes[0] = held_ff;
                     cmd.count    = (held_ff == MRK_PFX) ? CNT_W'(2) : CNT_W'(1);
                  end
                  held_in       = b;
                  held_valid_in = 1'b1;
               end
            end
            PH_DROP: begin
               phase_in = PH_DROP;
            end
            default: begin
               phase_in = PH_DROP;
            end
         endcase
      end
   end

   assign cmd_push = accept && (cmd.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         rem_ff        <= '0;
         len_hi_ff     <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         rem_ff        <= rem_in;
         len_hi_ff     <= len_hi_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

// ----- rtl/jmsr_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// jmsr_cmd_fifo
// Short command queue between the parser and the result expander.
// ----------------------------------------------------------------------------
module jmsr_cmd_fifo import jmsr_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == COUNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/jmsr_back.sv -----
// ----------------------------------------------------------------------------
// jmsr_back
// Result expander: walks each command one byte per cycle, while the output register is
// empty or being popped, into the output register.
// ----------------------------------------------------------------------------
module jmsr_back import jmsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    head_valid,
   output logic    head_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              load;
   logic              at_last;

   assign load    = head_valid && (!out_valid_ff || rsp_pop);
   assign at_last = ({1'b0, idx_ff} == (head.count - CNT_W'(1)));
   assign head_pop = load && at_last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_in.out_byte  = head.bytes[idx_ff];
         out_in.has_byte  = head.has_byte;
         out_in.run_last  = at_last;
         out_in.unit_end  = at_last && head.unit_end;
         out_in.malformed = at_last && head.malformed;
         out_valid_in     = 1'b1;
         idx_in           = at_last ? '0 : idx_ff + SLOT_W'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/jpeg_marker_stream_restorer.sv -----
// Path: an accepted byte's command is written into the command queue; its first result is
// loaded from the queue head into the output register once that register is free.
// Throughput: one input byte per cycle while req_full is low; the expander gives one result
// per cycle while the output is popped, so a byte that expands to N results holds the expander
// until all N are out, buffered by the CMD_DEPTH-entry command queue.
// Reset: synchronous, active high; returns parser, queue and output to empty.
// ----------------------------------------------------------------------------
// jpeg_marker_stream_restorer
// Restores a modified JPEG tile byte stream into a standard JPEG stream.
// ----------------------------------------------------------------------------
module jpeg_marker_stream_restorer import jmsr_pkg::*; #(
   parameter int CMD_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    fifo_empty, fifo_full;
   logic    head_pop;

   assign req_full = fifo_full;
   assign accept   = req_push && !fifo_full;

   jmsr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   jmsr_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (head_pop),
      .head      (head),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   jmsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!fifo_empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.unit_end) |-> rsp_data.run_last)
      else $error("tile end not on last result of its byte");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.has_byte) |-> (rsp_data.unit_end && rsp_data.malformed))
      else $error("status-only result without malformed end");

   a_malformed_at_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.malformed) |-> rsp_data.unit_end)
      else $error("malformed flag away from tile end");

   a_pop_without_cmd: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !fifo_empty)
      else $error("expander popped an empty command queue");
`endif

endmodule

// ----- dv/jmsr_restore_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsr_restore_checker
// Watches both queue ports of the marker stream restorer. It rebuilds the
// expected output stream from every input byte transfer and compares each
// result transfer, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
module jmsr_restore_checker import jmsr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      expect_left,
   output int      results_checked,
   output int      tiles_done,
   output int      tiles_bad
);

   localparam int REPORT_MAX = 10;

   phase_type         phase;
   logic [LEN_W-1:0]  seg_left;
   logic [BYTE_W-1:0] len_hi;
   logic [BYTE_W-1:0] held_byte;
   logic              held_valid;
   logic              bad_flag;

   rsp_type expected_stream[$];
   rsp_type step_out[$];
   rsp_type want;
   int      mismatches = 0;
   int      checked = 0;
   int      ends = 0;
   int      bad_ends = 0;

   function void clear_state();
      phase      = PH_PREFIX;
      seg_left   = '0;
      len_hi     = BYTE_ZERO;
      held_byte  = BYTE_ZERO;
      held_valid = 1'b0;
      bad_flag   = 1'b0;
   endfunction

   function void emit(input logic [BYTE_W-1:0] b);
      step_out.push_back('{out_byte: b, has_byte: 1'b1, run_last: 1'b0,
                           unit_end: 1'b0, malformed: 1'b0});
   endfunction

   function void emit_sos_tail();
      emit(BYTE_ZERO);
      emit(SOS_SE);
      emit(BYTE_ZERO);
   endfunction

   function void mark_bad();
      bad_flag = 1'b1;
      phase    = PH_DROP;
   endfunction

   task automatic restore_byte(input req_type r);
      logic [LEN_W-1:0]  seg_len;
      logic [BYTE_W-1:0] b;
      logic              tile_end;
      int                tail;
      b        = r.in_byte;
      tile_end = 1'b0;
      step_out.delete();
      if (r.unit_last && phase != PH_SCAN) begin
         bad_flag = 1'b1;
         tile_end = 1'b1;
         step_out.push_back('{out_byte: BYTE_ZERO, has_byte: 1'b0, run_last: 1'b0,
                              unit_end: 1'b0, malformed: 1'b0});
      end else begin
         case (phase)
            PH_PREFIX: begin
               if (b == MRK_PFX) phase = PH_MARKER;
               else mark_bad();
            end
            PH_MARKER: begin
               if (b == MRK_SOI) begin
                  emit(MRK_PFX);
                  emit(MRK_SOI);
                  phase = PH_PREFIX;
               end else if (b == MRK_APP) begin
                  phase = PH_PREFIX;
               end else if (b == MRK_SOF0 || b == MRK_DHT || b == MRK_DQT) begin
                  emit(MRK_PFX);
                  emit(b);
                  phase = PH_LEN_HI;
               end else if (b == MRK_SOS) begin
                  emit(MRK_PFX);
                  emit(MRK_SOS);
                  emit(BYTE_ZERO);
                  emit(SOS_LEN);
                  phase = PH_SOS_HI;
               end else begin
                  mark_bad();
               end
            end
            PH_LEN_HI, PH_SOS_HI: begin
               len_hi = b;
               phase  = (phase == PH_LEN_HI) ? PH_LEN_LO : PH_SOS_LO;
            end
            PH_LEN_LO: begin
               seg_len = {len_hi, b};
               if (seg_len < 2) begin
                  mark_bad();
               end else begin
                  emit(len_hi);
                  emit(b);
                  seg_left = seg_len - 16'd2;
                  phase    = (seg_left == 0) ? PH_PREFIX : PH_COPY;
               end
            end
            PH_COPY: begin
               emit(b);
               seg_left = seg_left - 16'd1;
               if (seg_left == 0) phase = PH_PREFIX;
            end
            PH_SOS_LO: begin
               seg_len = {len_hi, b};
               if (seg_len < 2) begin
                  mark_bad();
               end else begin
                  seg_left = seg_len - 16'd2;
                  if (seg_left == 0) begin
                     emit_sos_tail();
                     phase = PH_SCAN;
                  end else begin
                     phase = PH_SOS_HDR;
                  end
               end
            end
            PH_SOS_HDR: begin
               emit(b);
               seg_left = seg_left - 16'd1;
               if (seg_left == 0) begin
                  emit_sos_tail();
                  phase = PH_SCAN;
               end
            end
            PH_SCAN: begin
               if (r.unit_last) begin
                  if (held_valid && held_byte == MRK_PFX) emit(MRK_PFX);
                  emit(MRK_EOI);
                  tile_end = 1'b1;
               end else begin
                  if (held_valid) begin
                     emit(held_byte);
                     if (held_byte == MRK_PFX) emit(BYTE_ZERO);
                  end
                  held_byte  = b;
                  held_valid = 1'b1;
               end
            end
            default: phase = PH_DROP;
         endcase
      end
      tail = step_out.size() - 1;
      if (tile_end) begin
         step_out[tail].unit_end  = 1'b1;
         step_out[tail].malformed = bad_flag;
         ends++;
         if (bad_flag) bad_ends++;
         clear_state();
      end
      if (tail >= 0) step_out[tail].run_last = 1'b1;
      foreach (step_out[i]) expected_stream.push_back(step_out[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_stream.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_stream.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: byte %02h has %b last %b end %b bad %b",
                           rsp_data.out_byte, rsp_data.has_byte, rsp_data.run_last,
                           rsp_data.unit_end, rsp_data.malformed);
            end else begin
               want = expected_stream.pop_front();
               checked++;
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.has_byte !== want.has_byte ||
                   rsp_data.run_last !== want.run_last ||
                   rsp_data.unit_end !== want.unit_end ||
                   rsp_data.malformed !== want.malformed) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"result %0d mismatch: expected byte %02h has %b last %b ",
                               "end %b bad %b, got byte %02h has %b last %b end %b bad %b"},
                              checked, want.out_byte, want.has_byte, want.run_last,
                              want.unit_end, want.malformed, rsp_data.out_byte,
                              rsp_data.has_byte, rsp_data.run_last, rsp_data.unit_end,
                              rsp_data.malformed);
               end
            end
         end
         if (req_push && !req_full) restore_byte(req_data);
      end
      fail_count      <= mismatches;
      expect_left     <= expected_stream.size();
      results_checked <= checked;
      tiles_done      <= ends;
      tiles_bad       <= bad_ends;
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the marker stream restorer. A few directed tiles
// hit empty scans, stuffed prefixes, bad structure and early ends; random
// tiles follow, mostly well formed, under four sender/receiver idle mixes
// and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb import jmsr_pkg::*; ();

   localparam int ITEM_TARGET    = 310;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AFTER     = 30;
   localparam int HOLD_OFF       = 80;
   localparam int DRAIN_CYCLES   = 20;

   logic    clock;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int expect_left;
   int results_checked;
   int tiles_done;
   int tiles_bad;

   int idle_pct   = 0;
   int stall_pct  = 0;
   int items_sent = 0;

   logic [BYTE_W-1:0] tile_bytes[$];

   jpeg_marker_stream_restorer uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   jmsr_restore_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .expect_left     (expect_left),
      .results_checked (results_checked),
      .tiles_done      (tiles_done),
      .tiles_bad       (tiles_bad)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] rand_byte(input int pfx_pct);
      if ($urandom_range(0, 99) < pfx_pct) return MRK_PFX;
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_segment_marker();
      case ($urandom_range(0, 2))
         0:       return MRK_SOF0;
         1:       return MRK_DHT;
         default: return MRK_DQT;
      endcase
   endfunction

   task automatic send_tile();
      req_type item;
      foreach (tile_bytes[i]) begin
         item.in_byte   = tile_bytes[i];
         item.unit_last = (i == tile_bytes.size() - 1);
         while ($urandom_range(0, 99) < idle_pct) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
         req_push <= 1'b1;
         req_data <= item;
         @(posedge clock);
         while (req_full) @(posedge clock);
         items_sent++;
      end
   endtask

   // receiver: random stalls, plus one long hold-off
   initial begin
      int popped;
      bit held;
      popped = 0;
      held   = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) popped++;
         if (!held && popped >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      int nseg;
      int seg_len;
      int k;
      logic [BYTE_W-1:0] mk;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty scan
      tile_bytes = '{MRK_PFX, MRK_SOI, MRK_PFX, MRK_SOS, 8'h00, 8'h02, 8'h00};
      send_tile();
      // prefix held in scan ahead of the final byte
      tile_bytes = '{MRK_PFX, MRK_SOS, 8'h00, 8'h02, MRK_PFX, MRK_PFX};
      send_tile();
      // non-prefix where a marker is expected
      tile_bytes = '{8'h12, 8'h34};
      send_tile();
      // unknown marker
      tile_bytes = '{MRK_PFX, MRK_EOI, 8'h00};
      send_tile();
      // length below two
      tile_bytes = '{MRK_PFX, MRK_SOF0, 8'h00, 8'h01, 8'h00};
      send_tile();
      // max length, early end inside the segment
      tile_bytes = '{MRK_PFX, MRK_DQT, 8'hFF, 8'hFF, 8'h00};
      send_tile();

      while (items_sent < ITEM_TARGET) begin
         case (items_sent * 4 / ITEM_TARGET)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 88; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 88; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         tile_bytes.delete();
         if ($urandom_range(0, 9) < 8) begin
            tile_bytes.push_back(MRK_PFX);
            tile_bytes.push_back(MRK_SOI);
         end
         nseg = $urandom_range(0, 2);
         repeat (nseg) begin
            tile_bytes.push_back(MRK_PFX);
            if ($urandom_range(0, 4) == 0) begin
               tile_bytes.push_back(MRK_APP);
            end else begin
               seg_len = $urandom_range(2, 7);
               tile_bytes.push_back(pick_segment_marker());
               tile_bytes.push_back(BYTE_ZERO);
               tile_bytes.push_back(BYTE_W'(seg_len));
               repeat (seg_len - 2) tile_bytes.push_back(rand_byte(20));
            end
         end
         seg_len = $urandom_range(2, 6);
         tile_bytes.push_back(MRK_PFX);
         tile_bytes.push_back(MRK_SOS);
         tile_bytes.push_back(BYTE_ZERO);
         tile_bytes.push_back(BYTE_W'(seg_len));
         repeat (seg_len - 2) tile_bytes.push_back(rand_byte(20));
         repeat ($urandom_range(0, 10)) tile_bytes.push_back(rand_byte(30));
         tile_bytes.push_back(rand_byte(30));

         if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 3))
               0: begin
                  k = $urandom_range(0, tile_bytes.size() - 2);
                  while (tile_bytes.size() > k + 1) void'(tile_bytes.pop_back());
               end
               1: begin
                  k = $urandom_range(0, tile_bytes.size() - 1);
                  tile_bytes[k] = BYTE_W'($urandom);
               end
               2: begin
                  tile_bytes.delete();
                  repeat ($urandom_range(1, 6)) tile_bytes.push_back(rand_byte(40));
               end
               default: begin
                  mk = ($urandom_range(0, 3) == 0) ? MRK_SOS : pick_segment_marker();
                  tile_bytes.delete();
                  tile_bytes.push_back(MRK_PFX);
                  tile_bytes.push_back(mk);
                  tile_bytes.push_back(($urandom_range(0, 1) == 0) ? BYTE_ZERO
                                                                 : BYTE_W'($urandom));
                  tile_bytes.push_back(BYTE_W'($urandom));
                  repeat ($urandom_range(1, 5)) tile_bytes.push_back(rand_byte(20));
               end
            endcase
         end
         send_tile();
      end

      req_push  <= 1'b0;
      stall_pct = 0;
      while (expect_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input bytes in %0d tiles, %0d of them malformed",
               items_sent, tiles_done, tiles_bad);
      $display("checked %0d results over four idle mixes and one long output hold-off",
               results_checked);
      if (expect_left != 0)
         $display("%0d expected results never arrived", expect_left);
      if (fail_count == 0 && expect_left == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
